>>> hw/rtl/lfpf_pkg.sv
// ----------------------------------------------------------------------------
// lfpf_pkg
// Shared types, constants and helpers of the line follower with fork handling.
// ----------------------------------------------------------------------------
package lfpf_pkg;

  localparam int DEFAULT_TICK_BITS = 32;

  localparam int SPEED_W = 15;
  localparam int GAIN_W  = 16;
  localparam int TIME_W  = 31;
  localparam int HOLD_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int DRIVE_W = 16;

  localparam logic [SPEED_W-1:0] BASE_SPEED_RST   = 15'd1800;
  localparam logic [SPEED_W-1:0] FAST_SPEED_RST   = 15'd2000;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RST   = 15'd500;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST       = 16'd2502;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST       = 16'd9;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST       = 16'd2538;
  localparam logic [TIME_W-1:0]  LOST_TIMEOUT_RST = 31'd8000;
  localparam logic [HOLD_W-1:0]  FORK_HOLD_RST    = 16'd60;

  // error in hundredths
  localparam logic signed [8:0]  ERR_OUTER = 9'sd110;
  localparam logic signed [8:0]  ERR_SIDE  = 9'sd115;
  localparam logic signed [8:0]  ERR_LOST  = 9'sd175;
  localparam logic signed [8:0]  ERR_DEADBAND = 9'sd10;
  localparam logic signed [18:0] SUM_LIMIT = 19'sd100000;

  // 1/sqrt2 in q0.16
  localparam logic signed [17:0] INV_SQRT2_Q16 = 18'sd46341;

  // divide by 100 after the shift by 16; quotients above the clamp saturate anyway
  localparam logic [23:0] Q_CLAMP   = 24'd13107200;
  localparam logic [24:0] DIV_RECIP = 25'd21474837;
  localparam int          DIV_SHIFT = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SPEED   = 3'd0,
    CFG_FAST_SPEED   = 3'd1,
    CFG_SLOW_SPEED   = 3'd2,
    CFG_GAIN_P       = 3'd3,
    CFG_GAIN_I       = 3'd4,
    CFG_GAIN_D       = 3'd5,
    CFG_LOST_TIMEOUT = 3'd6,
    CFG_FORK_HOLD    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_t;

  typedef enum logic [1:0] {
    KIND_PID  = 2'd0,
    KIND_STOP = 2'd1,
    KIND_TURN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BUZ_KEEP    = 2'd0,
    BUZ_SILENCE = 2'd1,
    BUZ_TONE    = 2'd2
  } buz_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] fast_speed;
    logic [SPEED_W-1:0] slow_speed;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [TIME_W-1:0]  lost_timeout;
    logic [HOLD_W-1:0]  fork_hold;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    logic  turn_left;
    logic  use_slow;
    buz_t  buz;
    logic  run;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic signed [8:0] err;
    logic signed [17:0] sum;
    logic signed [9:0] d;
    logic signed [9:0] dold;
  } step_t;

  function automatic logic signed [DRIVE_W-1:0] sat16(input logic signed [19:0] v);
    logic signed [DRIVE_W-1:0] res;
    if (v > 20'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[DRIVE_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/lfpf_cfg.sv
// ----------------------------------------------------------------------------
// lfpf_cfg
// Configuration register file, one write per handshake.
// ----------------------------------------------------------------------------
module lfpf_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lfpf_pkg::cfg_t                      cfg
);
  import lfpf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_SPEED:   cfg_nxt.base_speed   = cfg_data[SPEED_W-1:0];
        CFG_FAST_SPEED:   cfg_nxt.fast_speed   = cfg_data[SPEED_W-1:0];
        CFG_SLOW_SPEED:   cfg_nxt.slow_speed   = cfg_data[SPEED_W-1:0];
        CFG_GAIN_P:       cfg_nxt.gain_p       = cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:       cfg_nxt.gain_i       = cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:       cfg_nxt.gain_d       = cfg_data[GAIN_W-1:0];
        CFG_LOST_TIMEOUT: cfg_nxt.lost_timeout = cfg_data[TIME_W-1:0];
        CFG_FORK_HOLD:    cfg_nxt.fork_hold    = cfg_data[HOLD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed   <= BASE_SPEED_RST;
      cfg_r.fast_speed   <= FAST_SPEED_RST;
      cfg_r.slow_speed   <= SLOW_SPEED_RST;
      cfg_r.gain_p       <= GAIN_P_RST;
      cfg_r.gain_i       <= GAIN_I_RST;
      cfg_r.gain_d       <= GAIN_D_RST;
      cfg_r.lost_timeout <= LOST_TIMEOUT_RST;
      cfg_r.fork_hold    <= FORK_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hw/rtl/lfpf_ctrl.sv
// ----------------------------------------------------------------------------
// lfpf_ctrl
// Sensor decode, fork and loss handling, integral and derivative history.
// State advances on each accepted word.
// ----------------------------------------------------------------------------
module lfpf_ctrl #(
  parameter int TICK_BITS = lfpf_pkg::DEFAULT_TICK_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          sense_left,
  input  logic                          sense_center,
  input  logic                          sense_right,
  input  logic [lfpf_pkg::TIME_W-1:0]   tick_count,
  input  lfpf_pkg::cfg_t                cfg,
  output lfpf_pkg::step_t               step
);
  import lfpf_pkg::*;

  localparam int CMP_W = (TICK_BITS > TIME_W) ? TICK_BITS : TIME_W;

  localparam logic [2:0] PAT_CENTER      = 3'b010;
  localparam logic [2:0] PAT_CENTER_RGT  = 3'b011;
  localparam logic [2:0] PAT_RIGHT       = 3'b001;
  localparam logic [2:0] PAT_CENTER_LFT  = 3'b110;
  localparam logic [2:0] PAT_LEFT        = 3'b100;
  localparam logic [2:0] PAT_SOLID       = 3'b111;

  steer_t                 steer_r, steer_nxt;
  logic                   fork_left_r, fork_left_nxt;
  logic                   in_fork_r, in_fork_nxt;
  logic                   forcing_r, forcing_nxt;
  logic                   on_bar_r, on_bar_nxt;
  logic [TICK_BITS-1:0]   lost_since_r, lost_since_nxt;
  logic [TICK_BITS-1:0]   fork_exit_r, fork_exit_nxt;
  logic signed [17:0]     sum_r, sum_nxt;
  logic signed [8:0]      prev_err_r, prev_err_nxt;
  logic signed [9:0]      hist0_r, hist0_nxt;
  logic signed [9:0]      hist1_r, hist1_nxt;
  logic                   slot_r, slot_nxt;

  logic [TICK_BITS-1:0]   tick;
  logic [TICK_BITS-1:0]   fork_since;
  logic [TICK_BITS-1:0]   lost_since;
  logic [TICK_BITS-1:0]   fork_diff;
  logic [TICK_BITS-1:0]   lost_diff;
  logic                   fork_over;
  logic                   lost_over;
  logic                   fork_pat;
  logic                   solid;
  logic                   no_line;
  logic                   done;
  logic signed [8:0]      err;
  logic signed [18:0]     sum_add;
  logic signed [9:0]      d;

  assign tick       = TICK_BITS'(tick_count);
  assign fork_since = (fork_exit_r == '0) ? tick : fork_exit_r;
  assign lost_since = (lost_since_r == '0) ? tick : lost_since_r;
  assign fork_diff  = tick - fork_since;
  assign lost_diff  = tick - lost_since;
  assign fork_over  = !fork_diff[TICK_BITS-1] &&
                      (CMP_W'(fork_diff) > CMP_W'(cfg.fork_hold));
  assign lost_over  = !lost_diff[TICK_BITS-1] &&
                      (CMP_W'(lost_diff) > CMP_W'(cfg.lost_timeout));
  assign fork_pat   = sense_left && !sense_center && sense_right;
  assign solid      = sense_left && sense_center && sense_right;

  always_comb begin
    steer_nxt      = steer_r;
    fork_left_nxt  = fork_left_r;
    in_fork_nxt    = in_fork_r;
    forcing_nxt    = forcing_r;
    on_bar_nxt     = on_bar_r;
    lost_since_nxt = lost_since_r;
    fork_exit_nxt  = fork_exit_r;
    sum_nxt        = sum_r;
    prev_err_nxt   = prev_err_r;
    hist0_nxt      = hist0_r;
    hist1_nxt      = hist1_r;
    slot_nxt       = slot_r;
    step.tag.kind      = KIND_PID;
    step.tag.turn_left = fork_left_r;
    step.tag.use_slow  = 1'b0;
    step.tag.buz       = BUZ_SILENCE;
    step.tag.run       = 1'b1;
    err       = '0;
    no_line   = 1'b0;
    done      = 1'b0;
    sum_add   = '0;
    d         = '0;

    // forced turn after leaving a fork
    if (in_fork_r && !fork_pat) begin
      fork_exit_nxt = fork_since;
      if (fork_over) begin
        in_fork_nxt = 1'b0;
      end else begin
        step.tag.kind = KIND_TURN;
        step.tag.buz  = BUZ_KEEP;
        steer_nxt     = fork_left_r ? STEER_LEFT : STEER_RIGHT;
        forcing_nxt   = 1'b1;
        done          = 1'b1;
      end
    end

    if (!done) begin
      if (forcing_r) begin
        forcing_nxt   = 1'b0;
        fork_left_nxt = !fork_left_r;
        step.tag.buz  = BUZ_TONE;
      end
      if (fork_pat && on_bar_r) begin
        sum_nxt        = '0;
        prev_err_nxt   = '0;
        lost_since_nxt = '0;
        step.tag.kind  = KIND_STOP;
        done           = 1'b1;
      end else if (fork_pat) begin
        in_fork_nxt       = 1'b1;
        fork_exit_nxt     = '0;
        step.tag.use_slow = 1'b1;
      end else begin
        in_fork_nxt = 1'b0;
        case ({sense_left, sense_center, sense_right})
          PAT_CENTER: begin
            steer_nxt = STEER_STRAIGHT;
          end
          PAT_CENTER_RGT: begin
            err = -ERR_SIDE;
            steer_nxt = STEER_RIGHT;
          end
          PAT_RIGHT: begin
            err = -ERR_OUTER;
            steer_nxt = STEER_RIGHT;
          end
          PAT_CENTER_LFT: begin
            err = ERR_SIDE;
            steer_nxt = STEER_LEFT;
          end
          PAT_LEFT: begin
            err = ERR_OUTER;
            steer_nxt = STEER_LEFT;
          end
          PAT_SOLID: begin
            step.tag.use_slow = 1'b1;
            on_bar_nxt = 1'b1;
          end
          default: begin
            no_line = 1'b1;
            lost_since_nxt = lost_since;
            if (prev_err_r > ERR_DEADBAND || prev_err_r < -ERR_DEADBAND) begin
              err = (prev_err_r > 9'sd0) ? ERR_LOST : -ERR_LOST;
            end else if (steer_r == STEER_LEFT) begin
              err = ERR_LOST;
            end else if (steer_r == STEER_RIGHT) begin
              err = -ERR_LOST;
            end
            if (lost_over) begin
              sum_nxt       = '0;
              step.tag.kind = KIND_STOP;
              step.tag.run  = 1'b0;
              done          = 1'b1;
            end
          end
        endcase
      end
    end

    if (!done) begin
      if (!no_line) begin
        lost_since_nxt = '0;
      end
      if (!solid) begin
        on_bar_nxt = 1'b0;
      end
      sum_add = 19'(sum_r) + 19'(err);
      if (sum_add > SUM_LIMIT) begin
        sum_nxt = 18'(SUM_LIMIT);
      end else if (sum_add < -SUM_LIMIT) begin
        sum_nxt = 18'(-SUM_LIMIT);
      end else begin
        sum_nxt = sum_add[17:0];
      end
      d = 10'(err) - 10'(prev_err_r);
      if (slot_r) begin
        hist1_nxt = d;
      end else begin
        hist0_nxt = d;
      end
      slot_nxt     = !slot_r;
      prev_err_nxt = err;
    end

    step.err  = err;
    step.sum  = sum_nxt;
    step.d    = d;
    step.dold = slot_r ? hist0_r : hist1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r      <= STEER_STRAIGHT;
      fork_left_r  <= 1'b0;
      in_fork_r    <= 1'b0;
      forcing_r    <= 1'b0;
      on_bar_r     <= 1'b1;
      lost_since_r <= '0;
      fork_exit_r  <= '0;
      sum_r        <= '0;
      prev_err_r   <= '0;
      hist0_r      <= '0;
      hist1_r      <= '0;
      slot_r       <= 1'b0;
    end else if (accept) begin
      steer_r      <= steer_nxt;
      fork_left_r  <= fork_left_nxt;
      in_fork_r    <= in_fork_nxt;
      forcing_r    <= forcing_nxt;
      on_bar_r     <= on_bar_nxt;
      lost_since_r <= lost_since_nxt;
      fork_exit_r  <= fork_exit_nxt;
      sum_r        <= sum_nxt;
      prev_err_r   <= prev_err_nxt;
      hist0_r      <= hist0_nxt;
      hist1_r      <= hist1_nxt;
      slot_r       <= slot_nxt;
    end
  end

endmodule

>>> hw/rtl/lfpf_pipe.sv
// ----------------------------------------------------------------------------
// lfpf_pipe
// Six stage pid datapath: gain products, derivative tap, scaling by 1/6553600,
// drive mixing and saturation, with the output register as the last stage.
// ----------------------------------------------------------------------------
module lfpf_pipe (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lfpf_pkg::step_t                      step,
  input  lfpf_pkg::cfg_t                       cfg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  drive_fl,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  drive_rl,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  drive_fr,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  drive_rr,
  output logic [1:0]                           buzzer,
  output logic                                 running
);
  import lfpf_pkg::*;

  localparam int NSTAGE = 6;

  typedef struct packed {
    tag_t               tag;
    logic signed [25:0] p1;
    logic signed [34:0] p2;
    logic signed [26:0] p3;
    logic signed [26:0] p4;
  } st2_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [35:0] a;
    logic signed [44:0] b;
  } st3_t;

  typedef struct packed {
    tag_t        tag;
    logic        neg;
    logic [23:0] qc;
  } st4_t;

  typedef struct packed {
    tag_t        tag;
    logic        neg;
    logic [17:0] mag;
  } st5_t;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] rdy;
  logic [NSTAGE-1:0] vin;

  step_t st1_r;
  st2_t  st2_r, st2_nxt;
  st3_t  st3_r, st3_nxt;
  st4_t  st4_r, st4_nxt;
  st5_t  st5_r, st5_nxt;

  logic signed [DRIVE_W-1:0] fl_r, rl_r, fr_r, rr_r;
  logic signed [DRIVE_W-1:0] fl_nxt, rl_nxt, fr_nxt, rr_nxt;
  buz_t buz_r;
  logic run_r;

  logic signed [16:0] gp_s, gi_s, gd_s;
  logic signed [52:0] n_w;
  logic [52:0]        nmag;
  logic [36:0]        q1;
  logic [48:0]        prod;
  logic signed [18:0] pid;
  logic signed [19:0] base_s;
  logic signed [19:0] lft;
  logic signed [19:0] rgt;
  logic signed [DRIVE_W-1:0] fast_s, slow_s;
  logic [SPEED_W-1:0] base;

  assign vin = {vld_r[NSTAGE-2:0], in_valid};

  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // gain products
  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});

  always_comb begin
    st2_nxt.tag = st1_r.tag;
    st2_nxt.p1  = gp_s * st1_r.err;
    st2_nxt.p2  = gi_s * st1_r.sum;
    st2_nxt.p3  = gd_s * st1_r.d;
    st2_nxt.p4  = gd_s * st1_r.dold;
  end

  // sum of scaled terms and the older derivative tap
  always_comb begin
    st3_nxt.tag = st2_r.tag;
    st3_nxt.a   = 36'(st2_r.p1) + 36'(st2_r.p2) + 36'(st2_r.p3);
    st3_nxt.b   = st2_r.p4 * INV_SQRT2_Q16;
  end

  // full numerator, magnitude, divide by 65536 and clamp
  always_comb begin
    n_w  = 53'($signed({st3_r.a, 16'h0000})) + 53'(st3_r.b);
    nmag = n_w[52] ? 53'(-n_w) : 53'(n_w);
    q1   = nmag[52:16];
    st4_nxt.tag = st3_r.tag;
    st4_nxt.neg = n_w[52];
    st4_nxt.qc  = (q1 > 37'(Q_CLAMP)) ? Q_CLAMP : q1[23:0];
  end

  // divide by 100 with a reciprocal
  always_comb begin
    prod = 49'(st4_r.qc) * 49'(DIV_RECIP);
    st5_nxt.tag = st4_r.tag;
    st5_nxt.neg = st4_r.neg;
    st5_nxt.mag = prod[48:DIV_SHIFT];
  end

  // drive mixing
  always_comb begin
    pid    = st5_r.neg ? -$signed({1'b0, st5_r.mag}) : $signed({1'b0, st5_r.mag});
    base   = st5_r.tag.use_slow ? cfg.slow_speed : cfg.base_speed;
    base_s = $signed({5'b00000, base});
    lft    = base_s - 20'(pid);
    rgt    = base_s + 20'(pid);
    fast_s = $signed({1'b0, cfg.fast_speed});
    slow_s = $signed({1'b0, cfg.slow_speed});
    case (st5_r.tag.kind)
      KIND_PID: begin
        fl_nxt = sat16(lft);
        rl_nxt = sat16(lft);
        fr_nxt = sat16(rgt);
        rr_nxt = sat16(rgt);
      end
      KIND_TURN: begin
        if (st5_r.tag.turn_left) begin
          fl_nxt = fast_s;
          rl_nxt = fast_s;
          fr_nxt = -slow_s;
          rr_nxt = -fast_s;
        end else begin
          fl_nxt = -slow_s;
          rl_nxt = -fast_s;
          fr_nxt = fast_s;
          rr_nxt = fast_s;
        end
      end
      default: begin
        fl_nxt = '0;
        rl_nxt = '0;
        fr_nxt = '0;
        rr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vin[0]) begin
      st1_r <= step;
    end
    if (rdy[1] && vin[1]) begin
      st2_r <= st2_nxt;
    end
    if (rdy[2] && vin[2]) begin
      st3_r <= st3_nxt;
    end
    if (rdy[3] && vin[3]) begin
      st4_r <= st4_nxt;
    end
    if (rdy[4] && vin[4]) begin
      st5_r <= st5_nxt;
    end
    if (rdy[5] && vin[5]) begin
      fl_r  <= fl_nxt;
      rl_r  <= rl_nxt;
      fr_r  <= fr_nxt;
      rr_r  <= rr_nxt;
      buz_r <= st5_r.tag.buz;
      run_r <= st5_r.tag.run;
    end
  end

  assign drive_fl = fl_r;
  assign drive_rl = rl_r;
  assign drive_fr = fr_r;
  assign drive_rr = rr_r;
  assign buzzer   = buz_r;
  assign running  = run_r;

endmodule

>>> hw/rtl/line_follower_pid_fork.sv
// ----------------------------------------------------------------------------
// line_follower_pid_fork
// Three sensor line follower with pid steering, forced turns after forks,
// stop on solid bars and stop on long line loss. One sensor word is taken
// per cycle while the output does not stall; each gives one result word.
// The steering state (integral, derivative history, fork and loss markers)
// is updated in the cycle the word is accepted, and the pid products, the
// older derivative tap, the scaling by 1/6553600 and the drive saturation
// run through a six register pipeline that ends in the output register.
// A stall on the output fills the pipeline's empty stages before the input
// stops. Configuration writes are always ready and are registered on acceptance.
// ----------------------------------------------------------------------------
module line_follower_pid_fork #(
  parameter int TICK_BITS = lfpf_pkg::DEFAULT_TICK_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_sense_left,
  input  logic                                 in_sense_center,
  input  logic                                 in_sense_right,
  input  logic [lfpf_pkg::TIME_W-1:0]          in_tick_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  out_drive_front_left,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  out_drive_rear_left,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  out_drive_front_right,
  output logic signed [lfpf_pkg::DRIVE_W-1:0]  out_drive_rear_right,
  output logic [1:0]                           out_buzzer_command,
  output logic                                 out_still_running,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lfpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfpf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lfpf_pkg::*;

  cfg_t  cfg;
  step_t step;
  logic  accept;

  assign accept = in_valid && in_ready;

  lfpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfpf_ctrl #(
    .TICK_BITS (TICK_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sense_left   (in_sense_left),
    .sense_center (in_sense_center),
    .sense_right  (in_sense_right),
    .tick_count   (in_tick_count),
    .cfg          (cfg),
    .step         (step)
  );

  lfpf_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .step      (step),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive_fl  (out_drive_front_left),
    .drive_rl  (out_drive_rear_left),
    .drive_fr  (out_drive_front_right),
    .drive_rr  (out_drive_rear_right),
    .buzzer    (out_buzzer_command),
    .running   (out_still_running)
  );

endmodule
